FILE: rtl/bdpc_pkg.sv
// types and constants for the button debounce and press classifier
// no dependencies; imported by button_debounce_press_classifier
`default_nettype none

package bdpc_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned TICKS_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [TICKS_W-1:0]   ticks_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// request opcodes
	localparam logic OP_POLL = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register indexes
	localparam cfg_idx_t CFG_DEBOUNCE   = 2'd0;
	localparam cfg_idx_t CFG_LONG_PRESS = 2'd1;

	localparam ticks_t DEBOUNCE_RST   = 16'd10;
	localparam ticks_t LONG_PRESS_RST = 16'd3000;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_LONG    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} event_t;

endpackage

`default_nettype wire

FILE: rtl/button_debounce_press_classifier.sv
// Sustains one request per clock while the result side does not stall: every request gives
// exactly one result, held first in the request register and then in the result register.
// The debounce check, the press/long-press machine and the event read-and-clear sit in
// the single combinational step between those two registers. Poll requests report the
// event as none; read requests return the pending event and clear it. The kept level
// (1 = pressed, pin active low) is reported with every result.
// depends on bdpc_pkg
`default_nettype none

module button_debounce_press_classifier (
	input  wire                     clk,
	input  wire                     arst_n,
	// request channel
	input  wire                     req_valid,
	output logic                    req_stall,
	input  wire                     op,
	input  wire                     pin_level,
	input  wire  bdpc_pkg::time_t   time_now,
	// result channel
	output logic                    res_valid,
	input  wire                     res_stall,
	output logic [1:0]              event_res,
	output logic                    stable_pressed,
	// register writes
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  bdpc_pkg::cfg_idx_t cfg_index,
	input  wire  bdpc_pkg::ticks_t  cfg_data
);
	import bdpc_pkg::*;

	// request register
	logic  valid_s1;
	logic  op_s1;
	logic  pin_s1;
	time_t time_s1;

	// result register
	logic       res_valid_q;
	logic [1:0] event_q;
	logic       pressed_q;

	// settings
	ticks_t debounce_q;
	ticks_t long_press_q;

	// block state
	logic   last_q;
	time_t  change_q;
	phase_t phase_q;
	time_t  press_q;
	event_t pend_q;

	// next state
	logic   last_d;
	time_t  change_d;
	phase_t phase_d;
	time_t  press_d;
	event_t pend_d;
	event_t evt_d;
	logic   settled;

	logic adv;
	logic take;

	assign adv       = valid_s1 && !(res_valid_q && res_stall);
	assign req_stall = valid_s1 && res_valid_q && res_stall;
	assign take      = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	assign res_valid      = res_valid_q;
	assign event_res      = event_q;
	assign stable_pressed = pressed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= op;
			pin_s1  <= pin_level;
			time_s1 <= time_now;
		end
	end

	always_comb begin
		last_d   = last_q;
		change_d = change_q;
		phase_d  = phase_q;
		press_d  = press_q;
		pend_d   = pend_q;
		evt_d    = EV_NONE;
		settled  = 1'b0;
		if (op_s1 == OP_READ) begin
			evt_d  = pend_q;
			pend_d = EV_NONE;
		end else begin
			last_d = ~pin_s1;
			if (last_d != last_q) begin
				change_d = time_s1;
			end
			settled = (time_s1 - change_d) >= time_t'(debounce_q);
			if (settled) begin
				unique case (phase_q)
					PH_IDLE: begin
						if (last_d) begin
							pend_d  = EV_SHORT;
							phase_d = PH_PRESSED;
							press_d = time_s1;
						end
					end
					PH_PRESSED: begin
						if (!last_d) begin
							phase_d = PH_IDLE;
						end else if ((time_s1 - press_q) >= time_t'(long_press_q)) begin
							pend_d  = EV_LONG;
							phase_d = PH_LONG;
						end
					end
					default: begin
						// long-held, and the unused code acts the same
						if (!last_d) begin
							phase_d = PH_IDLE;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			change_q <= '0;
			phase_q  <= PH_IDLE;
			press_q  <= '0;
			pend_q   <= EV_NONE;
		end else if (adv) begin
			last_q   <= last_d;
			change_q <= change_d;
			phase_q  <= phase_d;
			press_q  <= press_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_q   <= evt_d;
			pressed_q <= last_d;
		end
	end

	// long event only comes out of the pressed phase
	a_long_from_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == EV_LONG && $past(pend_q) != EV_LONG) |-> $past(phase_q) == PH_PRESSED)
		else $error("long event latched outside pressed phase");

	// leaving idle needs the kept level pressed
	a_press_needs_level: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE && $past(phase_q) == PH_IDLE) |-> last_q)
		else $error("left idle without kept press");

	// a read that completes leaves no pending event
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == OP_READ) |=> pend_q == EV_NONE)
		else $error("read did not clear pending event");

	// back-pressure only with a request held in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && res_valid_q))
		else $error("request stalled with room to advance");

endmodule

`default_nettype wire

FILE: sim/tb_button_debounce_press_classifier.sv
// testbench for button_debounce_press_classifier: bounced presses, long holds, reads and
// noise under several threshold settings, each result checked against an in-bench predictor
// depends on bdpc_pkg and the block itself; standalone, no files or arguments
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier;
	import bdpc_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned HOLD_CYCLES   = 80;
	localparam int unsigned NUM_SETTINGS  = 8;
	localparam int unsigned ITEMS_PER_SET = 250;

	typedef struct packed {
		event_t ev;
		logic   level;
	} press_result_t;

	// keeps its own copy of the press state and the thresholds
	class press_checker;
		ticks_t          debounce_ticks;
		ticks_t          long_ticks;
		logic            kept_level;
		time_t           change_t;
		phase_t          press_phase;
		time_t           press_t;
		event_t          latched;
		press_result_t   pending_results[$];
		int unsigned     errors;
		int unsigned     checked;
		int unsigned     shorts_read;
		int unsigned     longs_read;

		function new();
			debounce_ticks = DEBOUNCE_RST;
			long_ticks = LONG_PRESS_RST;
			kept_level = 1'b0;
			change_t = '0;
			press_phase = PH_IDLE;
			press_t = '0;
			latched = EV_NONE;
			errors = 0;
			checked = 0;
			shorts_read = 0;
			longs_read = 0;
		endfunction

		function void set_register(cfg_idx_t idx, ticks_t val);
			case (idx)
				CFG_DEBOUNCE: begin
					debounce_ticks = val;
				end
				CFG_LONG_PRESS: begin
					long_ticks = val;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_request(logic r_op, logic r_pin, time_t r_time);
			press_result_t want;
			time_t         since;
			logic          active;
			want.ev = EV_NONE;
			if (r_op == OP_POLL) begin
				active = ~r_pin;
				if (active != kept_level) begin
					kept_level = active;
					change_t = r_time;
				end
				since = r_time - change_t;
				if (since >= time_t'(debounce_ticks)) begin
					case (press_phase)
						PH_IDLE: begin
							if (kept_level) begin
								latched = EV_SHORT;
								press_phase = PH_PRESSED;
								press_t = r_time;
							end
						end
						PH_PRESSED: begin
							since = r_time - press_t;
							if (!kept_level)
								press_phase = PH_IDLE;
							else if (since >= time_t'(long_ticks)) begin
								latched = EV_LONG;
								press_phase = PH_LONG;
							end
						end
						default: begin
							if (!kept_level)
								press_phase = PH_IDLE;
						end
					endcase
				end
			end else begin
				want.ev = latched;
				if (latched == EV_SHORT)
					shorts_read++;
				if (latched == EV_LONG)
					longs_read++;
				latched = EV_NONE;
			end
			want.level = kept_level;
			pending_results.push_back(want);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [1:0] ev, logic level);
			press_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing expected (event %0d, level %0d)",
					ev, level));
			end else begin
				want = pending_results.pop_front();
				if (ev !== want.ev)
					report($sformatf("result %0d event_res: got %0d, expected %0d",
						checked, ev, want.ev));
				if (level !== want.level)
					report($sformatf("result %0d stable_pressed: got %0d, expected %0d",
						checked, level, want.level));
			end
			checked++;
		endtask
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	logic     op = OP_POLL;
	logic     pin_level = 1'b1;
	time_t    time_now = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	logic [1:0] event_res;
	logic     stable_pressed;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index = CFG_DEBOUNCE;
	ticks_t   cfg_data = '0;

	press_checker sb = new();
	time_t        tick = '0;
	int unsigned  sent = 0;
	int unsigned  quiet_cycles = 0;
	bit           req_idle_on = 1'b0;
	bit           res_stall_on = 1'b0;
	bit           hold_request = 1'b0;

	button_debounce_press_classifier dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.op             (op),
		.pin_level      (pin_level),
		.time_now       (time_now),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.event_res      (event_res),
		.stable_pressed (stable_pressed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: random stall bursts, plus one long hold-off on demand
	always begin
		@(negedge clk);
		if (hold_request) begin
			res_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_request = 1'b0;
			res_stall <= 1'b0;
		end else if (res_stall_on && $urandom_range(0, 7) == 0) begin
			res_stall <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			res_stall <= 1'b0;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(event_res, stable_pressed);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", quiet_cycles);
			$display("** button_debounce_press_classifier: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge, returns at a falling edge
	task send_request(input logic r_op, input logic r_pin, input time_t r_time);
		if (req_idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_valid <= 1'b1;
		op <= r_op;
		pin_level <= r_pin;
		time_now <= r_time;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r_op, r_pin, r_time);
		sent++;
		@(negedge clk);
	endtask

	task send_poll(input logic r_pin);
		send_request(OP_POLL, r_pin, tick);
	endtask

	task send_read();
		send_request(OP_READ, 1'($urandom()), time_t'($urandom()));
	endtask

	// let every result drain, then write both thresholds
	task set_thresholds(input ticks_t deb, input ticks_t lng);
		req_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_DEBOUNCE;
		cfg_data <= deb;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(CFG_DEBOUNCE, deb);
		@(negedge clk);
		cfg_index <= CFG_LONG_PRESS;
		cfg_data <= lng;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(CFG_LONG_PRESS, lng);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one bounced press, a hold of random length and a bounced release
	task run_press_cycle();
		int unsigned deb;
		int unsigned lng;
		int unsigned n;
		deb = sb.debounce_ticks;
		lng = sb.long_ticks;
		if ($urandom_range(0, 3) == 0)
			tick = $urandom();
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			tick += $urandom_range(0, deb / 2 + 1);
			send_poll(i[0]);
		end
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			tick += $urandom_range(0, deb + lng / 3 + 2);
			send_poll(1'b0);
			if ($urandom_range(0, 3) == 0)
				send_read();
		end
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			tick += $urandom_range(0, deb / 2 + 1);
			send_poll(~i[0]);
		end
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			tick += $urandom_range(0, deb + 2);
			send_poll(1'b1);
		end
		if ($urandom_range(0, 1) == 0)
			send_read();
	endtask

	task run_noise();
		repeat ($urandom_range(1, 4))
			send_request(1'($urandom()), 1'($urandom()), time_t'($urandom()));
	endtask

	initial begin
		int unsigned phase_end;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset thresholds: debounce 10, long press 3000
		send_read();
		send_poll(1'b1);
		tick = 5;
		send_poll(1'b0);
		tick = 14;
		send_poll(1'b0);
		tick = 15;
		send_poll(1'b0);
		send_read();
		send_read();
		tick = 3014;
		send_poll(1'b0);
		tick = 3015;
		send_poll(1'b0);
		send_request(OP_READ, 1'b0, 32'hFFFF_FFFF);
		tick = 3020;
		send_poll(1'b1);
		tick = 3030;
		send_poll(1'b1);
		// debounce across the wrap of the tick count, then an unread short overwritten
		tick = 32'hFFFF_FFFA;
		send_poll(1'b0);
		tick = 32'hFFFF_FFFF;
		send_poll(1'b0);
		tick = 4;
		send_poll(1'b0);
		tick = 3004;
		send_poll(1'b0);
		send_read();
		tick = 3010;
		send_poll(1'b1);
		tick = 3020;
		send_poll(1'b1);

		// zero debounce and zero long-press threshold
		set_thresholds('0, '0);
		tick = 100;
		send_poll(1'b1);
		send_poll(1'b0);
		send_poll(1'b0);
		send_read();
		send_poll(1'b1);
		send_read();

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			case (p)
				0: set_thresholds(DEBOUNCE_RST, LONG_PRESS_RST);
				1: set_thresholds('0, '0);
				2: set_thresholds('1, '1);
				3: set_thresholds('0, '1);
				4: set_thresholds('1, '0);
				default: set_thresholds(ticks_t'($urandom_range(1, 16)),
					ticks_t'($urandom_range(0, 64)));
			endcase
			req_idle_on = (p != NUM_SETTINGS - 1) && $urandom_range(0, 3) != 0;
			res_stall_on = (p != NUM_SETTINGS - 1) && $urandom_range(0, 3) != 0;
			// receiver holds off while requests keep coming, so the block backs up
			if (p == 5)
				hold_request = 1'b1;
			phase_end = sent + ITEMS_PER_SET;
			while (sent < phase_end) begin
				if ($urandom_range(0, 7) == 0)
					run_noise();
				else
					run_press_cycle();
			end
		end

		req_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d requests and %0d checked results over %0d threshold settings;",
			sent, sb.checked, NUM_SETTINGS + 2);
		$display("reads returned %0d short and %0d long press events", sb.shorts_read,
			sb.longs_read);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("** button_debounce_press_classifier: PASSED **");
		else
			$display("** button_debounce_press_classifier: FAILED **");
		$finish;
	end

endmodule
